@@ design/pgvu_pkg.sv @@
package pgvu_pkg;

  // default binary point position of the Q format
  localparam int FRAC_BITS_DEF = 16;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_DATA_W-1:0] GRAV_SCALE_RST = 32'd4374;
  localparam logic [CFG_DATA_W-1:0] TIME_STEP_RST  = 32'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRAV_SCALE = 1'b0,
    REG_TIME_STEP  = 1'b1
  } cfg_reg_t;

  // datapath widths
  localparam int AD_W   = 33;   // magnitude of a position offset
  localparam int R2_W   = 66;   // squared distance
  localparam int R_W    = 33;   // distance
  localparam int GMT_W  = 96;   // grav_scale * mass * time_step
  localparam int Q_W    = 67;   // scaled acceleration, caps at 2^67
  localparam int QCH_W  = 23;   // slice of the acceleration per partial product
  localparam int PP_W   = 56;   // partial product width
  localparam int PR_W   = 100;  // acceleration times offset
  localparam int C_W    = 34;   // per-axis velocity change
  localparam int SUM_W  = 36;   // velocity sum before clamping

  localparam logic [C_W-1:0] DV_CAP = 34'h2_0000_0000;

  typedef struct packed {
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic signed [31:0] source_x;
    logic signed [31:0] source_y;
    logic signed [31:0] source_z;
    logic        [31:0] source_mass;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_z;
    logic               coincident;
    logic               saturated;
  } out_word_t;

  // per-item values that travel alongside the arithmetic
  typedef struct packed {
    logic [2:0][AD_W-1:0] ad;
    logic [2:0]           neg;
    logic [2:0][31:0]     vel;
    logic                 coin;
  } item_t;

  localparam int ITEM_W = $bits(item_t);

endpackage

@@ design/pairwise_gravity_velocity_update.sv @@
// Pairwise gravity velocity update: one target/source interaction per word.
// Input channel in_valid/in_ready/in_word carries both positions, the source
// mass and the target velocity; the output channel out_valid/out_ready/
// out_word returns the updated velocity with the coincident and saturated
// flags. grav_scale (index 0) and time_step (index 1) are written through
// cfg_we/cfg_index/cfg_wdata; the user must write them only while the block
// is idle, as the block itself does not enforce this. A word passes a chain
// of bit-per-stage units: 33 square-root stages, 68 stages for the division
// by r^2 and 35 stages for the per-axis division by r, plus six register
// stages for offsets, products and the output register. Throughput is one
// word per cycle while in_ready is high: a new word may then enter.
// Reset (synchronous, active low) empties the pipeline and loads the default
// register values. When the receiver stalls, one more word is caught in a skid
// register; after that in_ready drops and the whole pipeline holds, nothing
// is lost or repeated. in_ready comes straight from a register.
module pairwise_gravity_velocity_update
  import pgvu_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_word,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_word,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int P_W = GMT_W + FRAC_BITS;

  localparam logic signed [SUM_W-1:0] VEL_MAX = 36'sd2147483647;
  localparam logic signed [SUM_W-1:0] VEL_MIN = -36'sd2147483648;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [CFG_DATA_W-1:0] grav_r;
  logic [CFG_DATA_W-1:0] tstep_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_r  <= GRAV_SCALE_RST;
      tstep_r <= TIME_STEP_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_GRAV_SCALE: grav_r  <= cfg_wdata;
        REG_TIME_STEP:  tstep_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // whole pipeline moves together, held only while the skid register is full
  logic pipe_en;
  logic skid_full_r;

  assign pipe_en  = ~skid_full_r;
  assign in_ready = pipe_en;

  // ---------------------------------------------------------------------------
  // stage 1: offsets, magnitudes and signs, grav_scale * mass
  // ---------------------------------------------------------------------------
  logic [2:0][31:0]   tgt_c;
  logic [2:0][31:0]   src_c;
  logic [2:0][AD_W-1:0] d_c;
  item_t              item_c;

  assign tgt_c = {in_word.target_z, in_word.target_y, in_word.target_x};
  assign src_c = {in_word.source_z, in_word.source_y, in_word.source_x};

  always_comb begin
    item_c.vel = {in_word.vel_z, in_word.vel_y, in_word.vel_x};
    for (int a = 0; a < 3; a++) begin
      d_c[a]        = {src_c[a][31], src_c[a]} - {tgt_c[a][31], tgt_c[a]};
      item_c.neg[a] = d_c[a][AD_W-1];
      item_c.ad[a]  = d_c[a][AD_W-1] ? (AD_W'(0) - d_c[a]) : d_c[a];
    end
    item_c.coin = (item_c.ad == '0);
  end

  logic        s1_v_r;
  item_t       s1_item_r;
  logic [63:0] gm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (pipe_en) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1_item_r <= item_c;
      gm_r      <= 64'(grav_r) * 64'(in_word.source_mass);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: squared offsets, partial products of g*m*t
  // ---------------------------------------------------------------------------
  logic                 s2_v_r;
  item_t                s2_item_r;
  logic [2:0][R2_W-1:0] sq_r;
  logic [63:0]          pl_r;
  logic [63:0]          ph_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (pipe_en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s2_item_r <= s1_item_r;
      for (int a = 0; a < 3; a++) begin
        sq_r[a] <= R2_W'(s1_item_r.ad[a]) * R2_W'(s1_item_r.ad[a]);
      end
      pl_r <= 64'(gm_r[31:0])  * 64'(tstep_r);
      ph_r <= 64'(gm_r[63:32]) * 64'(tstep_r);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: r^2 and the scaled numerator p = g*m*t * 2^frac
  // ---------------------------------------------------------------------------
  logic             s3_v_r;
  item_t            s3_item_r;
  logic [R2_W-1:0]  r2_r;
  logic [P_W-1:0]   p_r;
  logic [GMT_W-1:0] gmt_c;

  assign gmt_c = {ph_r, 32'd0} + GMT_W'(pl_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (pipe_en) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s3_item_r <= s2_item_r;
      r2_r      <= sq_r[0] + sq_r[1] + sq_r[2];
      p_r       <= {gmt_c, {FRAC_BITS{1'b0}}};
    end
  end

  // ---------------------------------------------------------------------------
  // distance r = floor(sqrt(r^2)), r^2 rebuilt exactly alongside
  // ---------------------------------------------------------------------------
  logic                  sq_v;
  logic [R_W-1:0]        root;
  logic [R2_W-1:0]       root_sq;
  logic [P_W+ITEM_W-1:0] sq_side;

  pgvu_isqrt #(
    .VW (R2_W),
    .RW (R_W),
    .SW (P_W + ITEM_W)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (s3_v_r),
    .in_val    (r2_r),
    .in_side   ({p_r, s3_item_r}),
    .out_valid (sq_v),
    .out_root  (root),
    .out_sq    (root_sq),
    .out_side  (sq_side)
  );

  // ---------------------------------------------------------------------------
  // q = floor(p / r^2), flagged when it reaches 2^67
  // ---------------------------------------------------------------------------
  logic [0:0][P_W-1:0]   d1_num;
  logic                  d1_v;
  logic [0:0][Q_W-1:0]   d1_quo;
  logic [0:0]            d1_ovf;
  logic [R_W+ITEM_W-1:0] d1_side;

  assign d1_num[0] = sq_side[ITEM_W +: P_W];

  pgvu_div #(
    .NW    (P_W),
    .DW    (R2_W),
    .QB    (Q_W),
    .LANES (1),
    .SW    (R_W + ITEM_W)
  ) u_div_acc (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (sq_v),
    .in_num    (d1_num),
    .in_den    (root_sq),
    .in_side   ({root, sq_side[ITEM_W-1:0]}),
    .out_valid (d1_v),
    .out_quo   (d1_quo),
    .out_ovf   (d1_ovf),
    .out_side  (d1_side)
  );

  // ---------------------------------------------------------------------------
  // q * |d| per axis: three partial products, then their sum
  // ---------------------------------------------------------------------------
  item_t                     d1_item;
  logic                      m1_v_r;
  item_t                     m1_item_r;
  logic [R_W-1:0]            m1_root_r;
  logic                      m1_qovf_r;
  logic [2:0][2:0][PP_W-1:0] m1_pp_r;

  assign d1_item = item_t'(d1_side[ITEM_W-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
    end else if (pipe_en) begin
      m1_v_r <= d1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      m1_item_r <= d1_item;
      m1_root_r <= d1_side[ITEM_W +: R_W];
      m1_qovf_r <= d1_ovf[0];
      for (int a = 0; a < 3; a++) begin
        m1_pp_r[a][0] <= PP_W'(d1_quo[0][QCH_W-1:0]) * PP_W'(d1_item.ad[a]);
        m1_pp_r[a][1] <= PP_W'(d1_quo[0][2*QCH_W-1:QCH_W]) * PP_W'(d1_item.ad[a]);
        m1_pp_r[a][2] <= PP_W'(d1_quo[0][Q_W-1:2*QCH_W]) * PP_W'(d1_item.ad[a]);
      end
    end
  end

  logic                 m2_v_r;
  item_t                m2_item_r;
  logic [R_W-1:0]       m2_root_r;
  logic                 m2_qovf_r;
  logic [2:0][PR_W-1:0] m2_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_v_r <= 1'b0;
    end else if (pipe_en) begin
      m2_v_r <= m1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      m2_item_r <= m1_item_r;
      m2_root_r <= m1_root_r;
      m2_qovf_r <= m1_qovf_r;
      for (int a = 0; a < 3; a++) begin
        m2_prod_r[a] <= PR_W'(m1_pp_r[a][0])
                      + (PR_W'(m1_pp_r[a][1]) << QCH_W)
                      + (PR_W'(m1_pp_r[a][2]) << (2 * QCH_W));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // per-axis change c = floor(q * |d| / r), three lanes sharing r
  // ---------------------------------------------------------------------------
  logic                  d2_v;
  logic [2:0][C_W-1:0]   d2_quo;
  logic [2:0]            d2_ovf;
  logic [ITEM_W:0]       d2_side;

  pgvu_div #(
    .NW    (PR_W),
    .DW    (R_W),
    .QB    (C_W),
    .LANES (3),
    .SW    (ITEM_W + 1)
  ) u_div_axis (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (m2_v_r),
    .in_num    (m2_prod_r),
    .in_den    (m2_root_r),
    .in_side   ({m2_qovf_r, m2_item_r}),
    .out_valid (d2_v),
    .out_quo   (d2_quo),
    .out_ovf   (d2_ovf),
    .out_side  (d2_side)
  );

  // ---------------------------------------------------------------------------
  // signed add, clamp to 32 bits, flags
  // ---------------------------------------------------------------------------
  item_t                      fin_item;
  logic                       fin_qovf;
  logic [2:0][C_W-1:0]        chg_c;
  logic signed [SUM_W-1:0]    sum_c [3];
  logic [2:0][31:0]           res_c;
  logic [2:0]                 clamp_c;
  out_word_t                  pipe_word;

  assign fin_item = item_t'(d2_side[ITEM_W-1:0]);
  assign fin_qovf = d2_side[ITEM_W];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (fin_item.ad[a] == '0) begin
        chg_c[a] = '0;
      end else if (fin_qovf || d2_ovf[a] || (d2_quo[a] > DV_CAP)) begin
        chg_c[a] = DV_CAP;
      end else begin
        chg_c[a] = d2_quo[a];
      end
      if (fin_item.neg[a]) begin
        sum_c[a] = {{(SUM_W-32){fin_item.vel[a][31]}}, fin_item.vel[a]}
                 - {{(SUM_W-C_W){1'b0}}, chg_c[a]};
      end else begin
        sum_c[a] = {{(SUM_W-32){fin_item.vel[a][31]}}, fin_item.vel[a]}
                 + {{(SUM_W-C_W){1'b0}}, chg_c[a]};
      end
      if (sum_c[a] > VEL_MAX) begin
        res_c[a]   = VEL_MAX[31:0];
        clamp_c[a] = 1'b1;
      end else if (sum_c[a] < VEL_MIN) begin
        res_c[a]   = VEL_MIN[31:0];
        clamp_c[a] = 1'b1;
      end else begin
        res_c[a]   = sum_c[a][31:0];
        clamp_c[a] = 1'b0;
      end
    end

    // coincident bodies pass the velocity through untouched
    if (fin_item.coin) begin
      pipe_word.new_vel_x  = fin_item.vel[0];
      pipe_word.new_vel_y  = fin_item.vel[1];
      pipe_word.new_vel_z  = fin_item.vel[2];
      pipe_word.coincident = 1'b1;
      pipe_word.saturated  = 1'b0;
    end else begin
      pipe_word.new_vel_x  = res_c[0];
      pipe_word.new_vel_y  = res_c[1];
      pipe_word.new_vel_z  = res_c[2];
      pipe_word.coincident = 1'b0;
      pipe_word.saturated  = |clamp_c;
    end
  end

  // ---------------------------------------------------------------------------
  // output register with one skid entry behind it
  // ---------------------------------------------------------------------------
  logic      out_valid_r;
  out_word_t out_word_r;
  out_word_t skid_r;
  logic      out_load;
  logic      skid_load;

  assign out_load  = ~out_valid_r | out_ready;
  assign skid_load = ~out_load & d2_v & ~skid_full_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (out_load) begin
      if (skid_full_r) begin
        out_valid_r <= 1'b1;
        skid_full_r <= 1'b0;
      end else begin
        out_valid_r <= d2_v;
      end
    end else if (skid_load) begin
      skid_full_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word_r <= skid_full_r ? skid_r : pipe_word;
    end
    if (skid_load) begin
      skid_r <= pipe_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

@@ design/pgvu_isqrt.sv @@
module pgvu_isqrt #(
  parameter int VW = 66,
  parameter int RW = 33,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [VW-1:0] in_val,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [RW-1:0] out_root,
  output logic [VW-1:0] out_sq,
  output logic [SW-1:0] out_side
);

  localparam int CW = VW + 2;

  // one result bit per stage, the square kept alongside the root
  logic          vld_r  [RW];
  logic [VW-1:0] val_r  [RW-1];
  logic [RW-1:0] root_r [RW];
  logic [VW-1:0] sq_r   [RW];
  logic [SW-1:0] side_r [RW];

  logic          a_vld  [RW];
  logic [VW-1:0] a_val  [RW];
  logic [RW-1:0] a_root [RW];
  logic [VW-1:0] a_sq   [RW];
  logic [SW-1:0] a_side [RW];

  assign a_vld[0]  = in_valid;
  assign a_val[0]  = in_val;
  assign a_root[0] = '0;
  assign a_sq[0]   = '0;
  assign a_side[0] = in_side;

  for (genvar k = 1; k < RW; k++) begin : g_link
    assign a_vld[k]  = vld_r[k-1];
    assign a_val[k]  = val_r[k-1];
    assign a_root[k] = root_r[k-1];
    assign a_sq[k]   = sq_r[k-1];
    assign a_side[k] = side_r[k-1];
  end

  for (genvar k = 0; k < RW; k++) begin : g_st
    localparam int B = RW - 1 - k;
    logic [CW-1:0] cand_sq;
    logic          take;

    // (root + 2^B)^2 = root^2 + root * 2^(B+1) + 2^(2B)
    always_comb begin
      cand_sq = CW'(a_sq[k]) + (CW'(a_root[k]) << (B + 1)) + (CW'(1) << (2 * B));
      take    = cand_sq <= CW'(a_val[k]);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= a_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[k] <= take ? (a_root[k] | (RW'(1) << B)) : a_root[k];
        sq_r[k]   <= take ? cand_sq[VW-1:0] : a_sq[k];
        side_r[k] <= a_side[k];
      end
    end

    if (k < RW - 1) begin : g_val
      always_ff @(posedge clk) begin
        if (en) begin
          val_r[k] <= a_val[k];
        end
      end
    end
  end

  assign out_valid = vld_r[RW-1];
  assign out_root  = root_r[RW-1];
  assign out_sq    = sq_r[RW-1];
  assign out_side  = side_r[RW-1];

endmodule

@@ design/pgvu_div.sv @@
module pgvu_div #(
  parameter int NW    = 112,
  parameter int DW    = 66,
  parameter int QB    = 67,
  parameter int LANES = 1,
  parameter int SW    = 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [LANES-1:0][NW-1:0]   in_num,
  input  logic [DW-1:0]              in_den,
  input  logic [SW-1:0]              in_side,
  output logic                       out_valid,
  output logic [LANES-1:0][QB-1:0]   out_quo,
  output logic [LANES-1:0]           out_ovf,
  output logic [SW-1:0]              out_side
);

  localparam int HW = NW - QB;
  localparam int CW = (HW > DW) ? HW : DW;

  // stage 0 checks the quotient range, stages 1..QB each settle one bit
  logic          vld_r  [QB+1];
  logic [DW-1:0] den_r  [QB];
  logic [SW-1:0] side_r [QB+1];
  logic [DW-1:0] rem_r  [QB][LANES];
  logic [QB-1:0] sh_r   [QB+1][LANES];   // numerator bits out, quotient bits in
  logic          ovf_r  [QB+1][LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r[0]  <= in_den;
      side_r[0] <= in_side;
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_pre
    logic [CW-1:0] hi_c;
    logic [CW-1:0] den_c;

    assign hi_c  = CW'(in_num[l][NW-1:QB]);
    assign den_c = CW'(in_den);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[0][l] <= hi_c[DW-1:0];
        sh_r[0][l]  <= in_num[l][QB-1:0];
        ovf_r[0][l] <= hi_c >= den_c;
      end
    end
  end

  for (genvar s = 1; s <= QB; s++) begin : g_st
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_r[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[s] <= side_r[s-1];
      end
    end

    if (s < QB) begin : g_den
      always_ff @(posedge clk) begin
        if (en) begin
          den_r[s] <= den_r[s-1];
        end
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_ln
      logic [DW:0] t_c;
      logic [DW:0] dif_c;
      logic        ge_c;

      assign t_c   = {rem_r[s-1][l], sh_r[s-1][l][QB-1]};
      assign dif_c = t_c - {1'b0, den_r[s-1]};
      assign ge_c  = t_c >= {1'b0, den_r[s-1]};

      always_ff @(posedge clk) begin
        if (en) begin
          sh_r[s][l]  <= {sh_r[s-1][l][QB-2:0], ge_c};
          ovf_r[s][l] <= ovf_r[s-1][l];
        end
      end

      if (s < QB) begin : g_rem
        always_ff @(posedge clk) begin
          if (en) begin
            rem_r[s][l] <= ge_c ? dif_c[DW-1:0] : t_c[DW-1:0];
          end
        end
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign out_quo[l] = sh_r[QB][l];
    assign out_ovf[l] = ovf_r[QB][l];
  end

  assign out_valid = vld_r[QB];
  assign out_side  = side_r[QB];

endmodule

@@ design/pgvu_chk.sv @@
module pgvu_chk
  import pgvu_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input in_word_t              in_word,
  input logic                  out_valid,
  input logic                  out_ready,
  input out_word_t             out_word,
  input logic                  cfg_we,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_wdata
);

  // a stalled word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("output word changed while stalled");

  // reset empties the output side
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // input only backs up behind a waiting result
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input held off with no result waiting");

  // coincident words are never clamped
  a_coin_nosat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_word.coincident && out_word.saturated))
    else $error("coincident word flagged as saturated");

  // a clamp leaves some component at a rail
  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.saturated |->
      out_word.new_vel_x == 32'sh7FFF_FFFF || out_word.new_vel_x == 32'sh8000_0000 ||
      out_word.new_vel_y == 32'sh7FFF_FFFF || out_word.new_vel_y == 32'sh8000_0000 ||
      out_word.new_vel_z == 32'sh7FFF_FFFF || out_word.new_vel_z == 32'sh8000_0000)
    else $error("saturated word without a clamped component");

endmodule

bind pairwise_gravity_velocity_update pgvu_chk u_chk (.*);
